>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: %m");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/lrh_pkg.sv
`default_nettype none

package lrh_pkg;

	// default configuration of the histogram
	localparam int LRH_NUM_BINS    = 7;
	localparam int LRH_COUNT_WIDTH = 32;

	// fixed field widths
	localparam int BYTE_W    = 8;
	localparam int RUN_W     = 20;
	localparam int POS_W     = 16;
	localparam int FC_W      = 8;
	localparam int TB_W      = 3;
	localparam int BIN_IDX_W = 3;
	localparam int VALUE_W   = 32;
	localparam int CFG_IDX_W = 2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CLASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_BIN     = 2'd2;

	// register reset values
	localparam logic [POS_W-1:0] BLOCK_BYTES_RST = 16'd16;
	localparam logic [FC_W-1:0]  FIRST_CLASS_RST = 8'd4;
	localparam logic [TB_W-1:0]  TOP_BIN_RST     = 3'd5;

	// output kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	// input commands
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_DUMP = 1'b1;

	typedef enum logic {
		ST_RUN,
		ST_DUMP
	} lrh_state_t;

	// controller -> datapath
	typedef struct packed {
		logic hold_in;
		logic dump_load;
		logic clear;
	} lrh_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic dump_pending;
		logic pipe_empty;
		logic out_ready;
		logic dump_last;
	} lrh_sts_t;

	// ones at the head of the byte (bit 7 first)
	function automatic logic [3:0] lead_ones(input logic [BYTE_W-1:0] b);
		logic [3:0] n;
		logic       run;
		n   = '0;
		run = 1'b1;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			run = run & b[i];
			n   = n + {3'b000, run};
		end
		return n;
	endfunction

	// ones at the tail of the byte (bit 0 side)
	function automatic logic [3:0] trail_ones(input logic [BYTE_W-1:0] b);
		logic [3:0] n;
		logic       run;
		n   = '0;
		run = 1'b1;
		for (int i = 0; i < BYTE_W; i++) begin
			run = run & b[i];
			n   = n + {3'b000, run};
		end
		return n;
	endfunction

	// longest run of ones inside the byte
	function automatic logic [3:0] max_run(input logic [BYTE_W-1:0] b);
		logic [3:0] cur;
		logic [3:0] best;
		cur  = '0;
		best = '0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			cur = b[i] ? cur + 4'd1 : 4'd0;
			if (cur > best) begin
				best = cur;
			end
		end
		return best;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lrh_cfg.sv
`default_nettype none

module lrh_cfg import lrh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data,
	output logic [POS_W-1:0]     block_bytes,
	output logic [FC_W-1:0]      first_class,
	output logic [TB_W-1:0]      top_bin
);

	logic [POS_W-1:0] block_bytes_q;
	logic [FC_W-1:0]  first_class_q;
	logic [TB_W-1:0]  top_bin_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RST;
			first_class_q <= FIRST_CLASS_RST;
			top_bin_q     <= TOP_BIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLOCK_BYTES: begin
					block_bytes_q <= cfg_data;
				end
				REG_FIRST_CLASS: begin
					first_class_q <= cfg_data[FC_W-1:0];
				end
				REG_TOP_BIN: begin
					top_bin_q <= cfg_data[TB_W-1:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	assign block_bytes = block_bytes_q;
	assign first_class = first_class_q;
	assign top_bin     = top_bin_q;

endmodule

`default_nettype wire

>>> rtl/lrh_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module lrh_ctrl import lrh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lrh_sts_t sts,
	output lrh_ctl_t ctl
);

	lrh_state_t state_q;
	lrh_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				// dump waits at the input stage until older blocks are binned
				if (sts.dump_pending && sts.pipe_empty) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (sts.out_ready && sts.dump_last) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl.hold_in   = sts.dump_pending;
		ctl.dump_load = 1'b0;
		ctl.clear     = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				ctl.dump_load = 1'b0;
			end
			ST_DUMP: begin
				ctl.dump_load = sts.out_ready;
				ctl.clear     = sts.out_ready && sts.dump_last;
			end
			default: begin
				ctl.dump_load = 1'b0;
			end
		endcase
	end

	`ASSERT_IMPLIES(a_dump_quiet, clk, arst_n, state_q == ST_DUMP, sts.pipe_empty && sts.dump_pending)
	`ASSERT_NEXT(a_dump_exit, clk, arst_n, ctl.clear, state_q == ST_RUN)

endmodule

`default_nettype wire

>>> rtl/lrh_dp.sv
`default_nettype none

`include "assert_macros.svh"

module lrh_dp import lrh_pkg::*; #(
	parameter int NUM_BINS    = LRH_NUM_BINS,
	parameter int COUNT_WIDTH = LRH_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [POS_W-1:0]     block_bytes,
	input  logic [FC_W-1:0]      first_class,
	input  logic [TB_W-1:0]      top_bin,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [BIN_IDX_W-1:0] bin_index,
	output logic [VALUE_W-1:0]   value,
	output logic                 last,
	input  lrh_ctl_t             ctl,
	output lrh_sts_t             sts
);

	localparam int IDX_W = $clog2(NUM_BINS);

	// handshake / advance
	logic adv;
	logic out_ready;
	logic in_acc;
	logic take_s1;
	logic load_s3;

	// stage 1: byte features
	logic       valid_s1;
	logic       cmd_s1;
	logic [3:0] lead_s1;
	logic [3:0] trail_s1;
	logic [3:0] maxrun_s1;

	// block state
	logic [RUN_W-1:0] cur_q;
	logic [RUN_W-1:0] longest_q;
	logic [POS_W-1:0] pos_q;
	logic [RUN_W:0]   cand_w;
	logic [RUN_W-1:0] cand_a;
	logic [RUN_W-1:0] long_a;
	logic [RUN_W-1:0] maxrun_ext;
	logic [RUN_W-1:0] new_cur;
	logic [RUN_W-1:0] new_long;
	logic [POS_W-1:0] pos_next;
	logic             close;

	// stage 2: closed block
	logic             rep_valid_s2;
	logic [RUN_W-1:0] rep_run_s2;

	// class of the closed block
	logic [IDX_W+TB_W-1:0] top_ext;
	logic [IDX_W+TB_W-1:0] top_max;
	logic [IDX_W+TB_W-1:0] top_lim;
	logic [IDX_W-1:0]      top_eff;
	logic [RUN_W:0]        diff;
	logic [IDX_W-1:0]      cls;

	// stage 3: classified report
	logic             valid_s3;
	logic [IDX_W-1:0] cls_s3;
	logic [RUN_W-1:0] run_s3;

	// bins and dump
	logic [COUNT_WIDTH-1:0]         bins_q [NUM_BINS];
	logic [IDX_W-1:0]               idx_q;
	logic [IDX_W-1:0]               rd_idx;
	logic [COUNT_WIDTH-1:0]         rd_val;
	logic [COUNT_WIDTH-1:0]         inc_val;
	logic [COUNT_WIDTH+VALUE_W-1:0] cnt_ext;
	logic [IDX_W+BIN_IDX_W-1:0]     cls_ext;
	logic [IDX_W+BIN_IDX_W-1:0]     idx_ext;

	// output register
	logic                 out_valid_q;
	logic                 kind_q;
	logic [BIN_IDX_W-1:0] bin_index_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 last_q;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv       = !valid_s3 || out_ready;
	assign in_stall  = !adv || ctl.hold_in;
	assign in_acc    = in_valid && !in_stall;
	assign take_s1   = adv && valid_s1 && (cmd_s1 == CMD_DATA);
	assign load_s3   = adv && valid_s3;

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (take_s1 || ctl.clear) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= cmd;
			lead_s1   <= lead_ones(data_byte);
			trail_s1  <= trail_ones(data_byte);
			maxrun_s1 <= max_run(data_byte);
		end
	end

	// ---- run update ----
	// lead is 8 on an all-ones byte, so cand_a is then the carried run as well
	assign cand_w     = {1'b0, cur_q} + (RUN_W + 1)'(lead_s1);
	assign cand_a     = cand_w[RUN_W-1:0];
	assign new_cur    = lead_s1[3] ? cand_a : RUN_W'(trail_s1);
	assign maxrun_ext = RUN_W'(maxrun_s1);
	// a carry means the run counter passed its maximum inside this byte before wrapping
	assign long_a     = cand_w[RUN_W] ? '1 : ((cand_a > longest_q) ? cand_a : longest_q);
	assign new_long   = (maxrun_ext > long_a) ? maxrun_ext : long_a;
	assign pos_next   = pos_q + POS_W'(1);
	assign close      = (pos_next == block_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			longest_q <= '0;
			pos_q     <= '0;
		end else if (ctl.clear || (take_s1 && close)) begin
			cur_q     <= '0;
			longest_q <= '0;
			pos_q     <= '0;
		end else if (take_s1) begin
			cur_q     <= new_cur;
			longest_q <= new_long;
			pos_q     <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_s2 <= 1'b0;
		end else if (adv) begin
			rep_valid_s2 <= take_s1 && close;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rep_run_s2 <= new_long;
		end
	end

	// ---- classify ----
	assign top_ext = {{IDX_W{1'b0}}, top_bin};
	assign top_max = (IDX_W + TB_W)'(NUM_BINS - 1);
	assign top_lim = (top_ext > top_max) ? top_max : top_ext;
	assign top_eff = top_lim[IDX_W-1:0];
	assign diff    = {1'b0, rep_run_s2} - (RUN_W + 1)'(first_class);

	always_comb begin
		if (diff[RUN_W]) begin
			cls = '0;
		end else if (diff[RUN_W-1:0] > RUN_W'(top_eff)) begin
			cls = top_eff;
		end else begin
			cls = diff[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= rep_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rep_valid_s2) begin
			cls_s3 <= cls;
			run_s3 <= rep_run_s2;
		end
	end

	// ---- bins ----
	assign rd_idx  = ctl.dump_load ? idx_q : cls_s3;
	assign rd_val  = bins_q[rd_idx];
	assign inc_val = (&rd_val) ? rd_val : rd_val + COUNT_WIDTH'(1);
	assign cnt_ext = {{VALUE_W{1'b0}}, rd_val};
	assign cls_ext = {{BIN_IDX_W{1'b0}}, cls_s3};
	assign idx_ext = {{BIN_IDX_W{1'b0}}, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else if (load_s3) begin
			bins_q[cls_s3] <= inc_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.clear) begin
			idx_q <= '0;
		end else if (ctl.dump_load) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= load_s3 || ctl.dump_load;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			kind_q      <= KIND_REPORT;
			bin_index_q <= cls_ext[BIN_IDX_W-1:0];
			value_q     <= VALUE_W'(run_s3);
			last_q      <= 1'b1;
		end else if (ctl.dump_load) begin
			kind_q      <= KIND_DUMP;
			bin_index_q <= idx_ext[BIN_IDX_W-1:0];
			value_q     <= cnt_ext[VALUE_W-1:0];
			last_q      <= sts.dump_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign bin_index = bin_index_q;
	assign value     = value_q;
	assign last      = last_q;

	assign sts.dump_pending = valid_s1 && (cmd_s1 == CMD_DUMP);
	assign sts.pipe_empty   = !rep_valid_s2 && !valid_s3;
	assign sts.out_ready    = out_ready;
	assign sts.dump_last    = (idx_q == IDX_W'(NUM_BINS - 1));

	`ASSERT_ALWAYS(a_no_collide, clk, arst_n, !(ctl.dump_load && valid_s3))
	`ASSERT_NEXT(a_clear_block, clk, arst_n, ctl.clear, cur_q == '0 && longest_q == '0 && pos_q == '0 && !valid_s1)

endmodule

`default_nettype wire

>>> rtl/longest_run_of_ones_histogram_unit.sv
// Data bytes: one transfer per cycle while in_stall is low; the block report of a closing
// byte passes the feature, run-update and classify registers into the output register,
// held back by output stalls. Dump: the controller starts it once the dump command is in
// stage 1 and the stages are empty, then loads NUM_BINS counts, one per free output cycle;
// input resumes in the cycle after the last. Reset (arst_n low, asynchronous): bins, run
// state and handshakes clear; block_bytes 16, first_class 4, top_bin 5.
`default_nettype none

module longest_run_of_ones_histogram_unit import lrh_pkg::*; #(
	parameter int NUM_BINS    = LRH_NUM_BINS,    // 2..8
	parameter int COUNT_WIDTH = LRH_COUNT_WIDTH  // 8..32, saturating bin counters
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POS_W-1:0]     cfg_data,

	// input items
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [BYTE_W-1:0]    data_byte,

	// result items
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [BIN_IDX_W-1:0] bin_index,
	output logic [VALUE_W-1:0]   value,
	output logic                 last
);

	// Structure:
	//   lrh_cfg  - the three configuration registers, always ready.
	//   lrh_dp   - stage 1 registers per-byte run features (leading ones, trailing
	//              ones, longest inner run); the run update then folds a whole byte
	//              into the current/longest run in one add and two compares. A
	//              closing byte hands its longest run to the classify stage, whose
	//              result is loaded into the output register while the matching bin
	//              takes a saturating increment.
	//   lrh_ctrl - sequences a dump: holds the input while the dump command sits in
	//              stage 1, lets older reports drain into the bins, then walks the
	//              bin index once per free output slot and clears everything at the end.
	// The output register acts as the skid point: bytes that close no block keep
	// flowing while a report waits, and outside a dump input stalls only if a
	// second report is ready behind a stalled one.

	logic [POS_W-1:0] block_bytes;
	logic [FC_W-1:0]  first_class;
	logic [TB_W-1:0]  top_bin;
	lrh_ctl_t         ctl;
	lrh_sts_t         sts;

	lrh_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.block_bytes (block_bytes),
		.first_class (first_class),
		.top_bin     (top_bin)
	);

	lrh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	lrh_dp #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.block_bytes (block_bytes),
		.first_class (first_class),
		.top_bin     (top_bin),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.bin_index   (bin_index),
		.value       (value),
		.last        (last),
		.ctl         (ctl),
		.sts         (sts)
	);

endmodule

`default_nettype wire
